FILE: hw/rtl/tpt_pkg.sv
// Shared types and codes for the task priority table.
package tpt_pkg;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_EDIT   = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_EXEC   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_EXECUTED = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_FULL     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	// control part of the scan wave handed from cell to cell
	typedef struct packed {
		logic  active;
		kind_t kind;
		logic  done;
		logic  best_valid;
		logic  match_valid;
	} wave_ctl_t;

endpackage

FILE: hw/rtl/tpt_cell.sv
// One table slot: holds an entry and processes the scan wave passing through it.
module tpt_cell #(
	parameter int ID_W   = 16,
	parameter int PRIO_W = 16,
	parameter int IDX_W  = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  slot_idx,
	input  logic              kill_en,
	input  logic [IDX_W-1:0]  kill_idx,
	input  tpt_pkg::wave_ctl_t in_ctl,
	input  logic [ID_W-1:0]   in_user,
	input  logic [ID_W-1:0]   in_task,
	input  logic [PRIO_W-1:0] in_prio,
	input  logic [ID_W-1:0]   in_best_user,
	input  logic [ID_W-1:0]   in_best_task,
	input  logic [PRIO_W-1:0] in_best_prio,
	input  logic [IDX_W-1:0]  in_best_idx,
	input  logic [IDX_W-1:0]  in_match_idx,
	output tpt_pkg::wave_ctl_t out_ctl,
	output logic [ID_W-1:0]   out_user,
	output logic [ID_W-1:0]   out_task,
	output logic [PRIO_W-1:0] out_prio,
	output logic [ID_W-1:0]   out_best_user,
	output logic [ID_W-1:0]   out_best_task,
	output logic [PRIO_W-1:0] out_best_prio,
	output logic [IDX_W-1:0]  out_best_idx,
	output logic [IDX_W-1:0]  out_match_idx
);

	logic              valid_q;
	logic [ID_W-1:0]   user_q;
	logic [ID_W-1:0]   task_q;
	logic [PRIO_W-1:0] prio_q;

	tpt_pkg::wave_ctl_t ctl_q;
	logic [ID_W-1:0]   wuser_q;
	logic [ID_W-1:0]   wtask_q;
	logic [PRIO_W-1:0] wprio_q;
	logic [ID_W-1:0]   best_user_q;
	logic [ID_W-1:0]   best_task_q;
	logic [PRIO_W-1:0] best_prio_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [IDX_W-1:0]  match_idx_q;

	logic task_eq;
	logic above;
	logic hit_free;
	logic hit_edit;
	logic hit_rm;
	logic hit_exec;
	tpt_pkg::wave_ctl_t ctl_d;

	assign task_eq  = valid_q && (task_q == in_task);
	// rank by priority, then task id, then user id; ties keep the lower slot
	assign above    = valid_q && (!in_ctl.best_valid ||
		({prio_q, task_q, user_q} > {in_best_prio, in_best_task, in_best_user}));
	assign hit_free = in_ctl.active && (in_ctl.kind == tpt_pkg::KIND_ADD) &&
		!in_ctl.done && !valid_q;
	assign hit_edit = in_ctl.active && (in_ctl.kind == tpt_pkg::KIND_EDIT) &&
		!in_ctl.done && task_eq;
	assign hit_rm   = in_ctl.active && (in_ctl.kind == tpt_pkg::KIND_REMOVE) && task_eq;
	assign hit_exec = in_ctl.active && (in_ctl.kind == tpt_pkg::KIND_EXEC) && above;

	always_comb begin
		ctl_d             = in_ctl;
		ctl_d.done        = in_ctl.done | hit_free | hit_edit;
		ctl_d.match_valid = in_ctl.match_valid | hit_rm;
		ctl_d.best_valid  = in_ctl.best_valid | hit_exec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ctl_q   <= '0;
		end else begin
			ctl_q <= ctl_d;
			if (hit_free) begin
				valid_q <= 1'b1;
			end else if (kill_en && (kill_idx == slot_idx)) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_free) begin
			user_q <= in_user;
			task_q <= in_task;
		end
		if (hit_free || hit_edit) begin
			prio_q <= in_prio;
		end
		wuser_q     <= in_user;
		wtask_q     <= in_task;
		wprio_q     <= in_prio;
		best_user_q <= hit_exec ? user_q   : in_best_user;
		best_task_q <= hit_exec ? task_q   : in_best_task;
		best_prio_q <= hit_exec ? prio_q   : in_best_prio;
		best_idx_q  <= hit_exec ? slot_idx : in_best_idx;
		// last match seen is the highest slot
		match_idx_q <= hit_rm ? slot_idx : in_match_idx;
	end

	assign out_ctl       = ctl_q;
	assign out_user      = wuser_q;
	assign out_task      = wtask_q;
	assign out_prio      = wprio_q;
	assign out_best_user = best_user_q;
	assign out_best_task = best_task_q;
	assign out_best_prio = best_prio_q;
	assign out_best_idx  = best_idx_q;
	assign out_match_idx = match_idx_q;

endmodule

FILE: hw/rtl/task_priority_table.sv
// Task priority table: a chain of slot cells scanned by one wave per request.
// A request wave passes one cell per cycle, so the chain length sets the timing.
// A new request is accepted only once the previous wave has left the chain and any
// result it returns has been loaded into the output register, which may stall on out_ready.
// Reset clears every slot's valid bit and all control; entry contents are undefined.
module task_priority_table #(
	parameter int CAPACITY  = 64,
	parameter int ID_BITS   = 16,
	parameter int PRIO_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] user_id,
	input  logic [15:0] task_id,
	input  logic [15:0] priority_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] owner_out
);

	localparam int IDX_W = $clog2(CAPACITY);

	tpt_pkg::state_t state_q, state_d;

	logic                 head_active_q;
	tpt_pkg::kind_t       head_kind_q;
	logic [ID_BITS-1:0]   head_user_q;
	logic [ID_BITS-1:0]   head_task_q;
	logic [PRIO_BITS-1:0] head_prio_q;

	tpt_pkg::wave_ctl_t   w_ctl       [CAPACITY+1];
	logic [ID_BITS-1:0]   w_user      [CAPACITY+1];
	logic [ID_BITS-1:0]   w_task      [CAPACITY+1];
	logic [PRIO_BITS-1:0] w_prio      [CAPACITY+1];
	logic [ID_BITS-1:0]   w_best_user [CAPACITY+1];
	logic [ID_BITS-1:0]   w_best_task [CAPACITY+1];
	logic [PRIO_BITS-1:0] w_best_prio [CAPACITY+1];
	logic [IDX_W-1:0]     w_best_idx  [CAPACITY+1];
	logic [IDX_W-1:0]     w_match_idx [CAPACITY+1];

	tpt_pkg::wave_ctl_t tail;
	logic               tail_here;
	logic               need_res;
	tpt_pkg::status_t   res_status_d;
	logic [15:0]        res_owner_d;
	logic               kill_en;
	logic [IDX_W-1:0]   kill_idx;
	logic               accept;
	logic               res_load;
	logic               out_load;

	tpt_pkg::status_t   res_status_q;
	logic [15:0]        res_owner_q;
	logic               out_valid_q;
	tpt_pkg::status_t   status_q;
	logic [15:0]        owner_q;

	assign accept = in_valid && in_ready;

	// chain head
	assign w_ctl[0] = '{active: head_active_q, kind: head_kind_q, done: 1'b0,
		best_valid: 1'b0, match_valid: 1'b0};
	assign w_user[0]      = head_user_q;
	assign w_task[0]      = head_task_q;
	assign w_prio[0]      = head_prio_q;
	assign w_best_user[0] = '0;
	assign w_best_task[0] = '0;
	assign w_best_prio[0] = '0;
	assign w_best_idx[0]  = '0;
	assign w_match_idx[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		tpt_cell #(
			.ID_W   (ID_BITS),
			.PRIO_W (PRIO_BITS),
			.IDX_W  (IDX_W)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.slot_idx      (IDX_W'(i)),
			.kill_en       (kill_en),
			.kill_idx      (kill_idx),
			.in_ctl        (w_ctl[i]),
			.in_user       (w_user[i]),
			.in_task       (w_task[i]),
			.in_prio       (w_prio[i]),
			.in_best_user  (w_best_user[i]),
			.in_best_task  (w_best_task[i]),
			.in_best_prio  (w_best_prio[i]),
			.in_best_idx   (w_best_idx[i]),
			.in_match_idx  (w_match_idx[i]),
			.out_ctl       (w_ctl[i+1]),
			.out_user      (w_user[i+1]),
			.out_task      (w_task[i+1]),
			.out_prio      (w_prio[i+1]),
			.out_best_user (w_best_user[i+1]),
			.out_best_task (w_best_task[i+1]),
			.out_best_prio (w_best_prio[i+1]),
			.out_best_idx  (w_best_idx[i+1]),
			.out_match_idx (w_match_idx[i+1])
		);
	end

	// chain tail: resolve the request
	assign tail      = w_ctl[CAPACITY];
	assign tail_here = tail.active && (state_q == tpt_pkg::S_SCAN);

	always_comb begin
		need_res     = 1'b0;
		res_status_d = tpt_pkg::STAT_EMPTY;
		res_owner_d  = '0;
		kill_en      = 1'b0;
		kill_idx     = w_best_idx[CAPACITY];
		unique case (tail.kind)
			tpt_pkg::KIND_ADD: begin
				need_res     = !tail.done;
				res_status_d = tpt_pkg::STAT_FULL;
			end
			tpt_pkg::KIND_EDIT: begin
			end
			tpt_pkg::KIND_REMOVE: begin
				kill_en  = tail_here && tail.match_valid;
				kill_idx = w_match_idx[CAPACITY];
			end
			tpt_pkg::KIND_EXEC: begin
				need_res = 1'b1;
				kill_en  = tail_here && tail.best_valid;
				if (tail.best_valid) begin
					res_status_d = tpt_pkg::STAT_EXECUTED;
					res_owner_d  = 16'(w_best_user[CAPACITY]);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		res_load = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			tpt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = tpt_pkg::S_SCAN;
				end
			end
			tpt_pkg::S_SCAN: begin
				if (tail.active) begin
					res_load = need_res;
					state_d  = need_res ? tpt_pkg::S_RESP : tpt_pkg::S_IDLE;
				end
			end
			tpt_pkg::S_RESP: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = tpt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tpt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tpt_pkg::S_IDLE;
			head_active_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			head_active_q <= accept;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_kind_q <= tpt_pkg::kind_t'(kind);
			head_user_q <= ID_BITS'(user_id);
			head_task_q <= ID_BITS'(task_id);
			head_prio_q <= PRIO_BITS'(priority_req);
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_owner_q  <= res_owner_d;
		end
		if (out_load) begin
			status_q <= res_status_q;
			owner_q  <= res_owner_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign owner_out = owner_q;

	// an injected wave must reach the chain tail, passing through the register of every cell
	a_wave_transit: assert property (@(posedge clk) disable iff (!arst_n)
		head_active_q |-> ##CAPACITY w_ctl[CAPACITY].active)
		else $error("scan wave did not reach chain tail on time");

	// only one request in the chain at a time
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		w_ctl[CAPACITY].active |-> (state_q == tpt_pkg::S_SCAN) && !head_active_q)
		else $error("wave at tail outside scan");

	// an add that found no free slot reports full
	a_full_report: assert property (@(posedge clk) disable iff (!arst_n)
		tail_here && (tail.kind == tpt_pkg::KIND_ADD) && !tail.done
		|=> (state_q == tpt_pkg::S_RESP) && (res_status_q == tpt_pkg::STAT_FULL))
		else $error("dropped add not reported full");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the task priority table: directed table, then random request mix.
`timescale 1ns / 1ps

module tb;

	localparam int SLOTS        = 64;
	localparam int TOTAL_ITEMS  = 1300;
	localparam int LIMIT_CYCLES = 600000;
	localparam int DIR_ROWS     = 25;

	typedef struct packed {
		tpt_pkg::status_t status;
		logic [15:0]      owner;
	} exec_result_t;

	typedef struct packed {
		tpt_pkg::kind_t   kind;
		logic [15:0]      user;
		logic [15:0]      tid;
		logic [15:0]      prio;
		logic             typed;
		tpt_pkg::status_t st;
		logic [15:0]      own;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [15:0] user_id;
	logic [15:0] task_id;
	logic [15:0] priority_req;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [15:0] owner_out;

	task_priority_table #(
		.CAPACITY (SLOTS),
		.ID_BITS  (16),
		.PRIO_BITS(16)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.user_id     (user_id),
		.task_id     (task_id),
		.priority_req(priority_req),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.owner_out   (owner_out)
	);

	// shadow copy of the slot contents
	bit          tbl_live [SLOTS];
	logic [15:0] tbl_user [SLOTS];
	logic [15:0] tbl_task [SLOTS];
	logic [15:0] tbl_prio [SLOTS];

	exec_result_t due_results[$];
	dir_row_t     directed_rows [DIR_ROWS];
	int           mismatches;
	int           sent_count;
	int           cycles;
	bit           idle_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
		$display("MISMATCH at %0t: %s expected %h got %h", $realtime, what, want, got);
		mismatches++;
	endtask

	function automatic bit outranks(input int a, input int b);
		if (tbl_prio[a] != tbl_prio[b])
			return tbl_prio[a] > tbl_prio[b];
		if (tbl_task[a] != tbl_task[b])
			return tbl_task[a] > tbl_task[b];
		return tbl_user[a] > tbl_user[b];
	endfunction

	function automatic int live_entries();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			n += tbl_live[i];
		return n;
	endfunction

	// update the shadow slots for one accepted request and return its result, if any
	task automatic predict_request(input tpt_pkg::kind_t k, input logic [15:0] u,
			input logic [15:0] t, input logic [15:0] p, output bit has,
			output exec_result_t res);
		int hit;
		hit = -1;
		has = 1'b0;
		res.status = tpt_pkg::STAT_EXECUTED;
		res.owner = '0;
		case (k)
			tpt_pkg::KIND_ADD: begin
				for (int i = 0; i < SLOTS; i++)
					if (!tbl_live[i] && hit < 0)
						hit = i;
				if (hit < 0) begin
					has = 1'b1;
					res.status = tpt_pkg::STAT_FULL;
				end else begin
					tbl_live[hit] = 1'b1;
					tbl_user[hit] = u;
					tbl_task[hit] = t;
					tbl_prio[hit] = p;
				end
			end
			tpt_pkg::KIND_EDIT: begin
				// lowest matching slot
				for (int i = 0; i < SLOTS; i++)
					if (tbl_live[i] && tbl_task[i] == t && hit < 0)
						hit = i;
				if (hit >= 0)
					tbl_prio[hit] = p;
			end
			tpt_pkg::KIND_REMOVE: begin
				// highest matching slot
				for (int i = SLOTS - 1; i >= 0; i--)
					if (tbl_live[i] && tbl_task[i] == t && hit < 0)
						hit = i;
				if (hit >= 0)
					tbl_live[hit] = 1'b0;
			end
			default: begin
				for (int i = 0; i < SLOTS; i++)
					if (tbl_live[i] && (hit < 0 || outranks(i, hit)))
						hit = i;
				has = 1'b1;
				if (hit < 0) begin
					res.status = tpt_pkg::STAT_EMPTY;
				end else begin
					tbl_live[hit] = 1'b0;
					res.owner = tbl_user[hit];
				end
			end
		endcase
	endtask

	task automatic issue(input tpt_pkg::kind_t k, input logic [15:0] u, input logic [15:0] t,
			input logic [15:0] p, input bit typed = 1'b0,
			input tpt_pkg::status_t tst = tpt_pkg::STAT_EXECUTED,
			input logic [15:0] town = '0);
		int gap;
		bit has;
		exec_result_t res;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind <= k;
		user_id <= u;
		task_id <= t;
		priority_req <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		predict_request(k, u, t, p, has, res);
		if (typed) begin
			res.status = tst;
			res.owner = town;
			due_results = {due_results, res};
		end else if (has) begin
			due_results = {due_results, res};
		end
		sent_count++;
	endtask

	// withdraw the last request, then wait for every outstanding result
	task automatic wait_drained();
		@(negedge clk) in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] pick_user();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom_range(0, 3));
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_prio();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 3));
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly ids that are live or from a small pool, so edits and removes hit
	function automatic logic [15:0] pick_task();
		int s;
		s = $urandom_range(0, SLOTS - 1);
		if ($urandom_range(0, 3) != 0 && tbl_live[s])
			return tbl_task[s];
		if ($urandom_range(0, 1) != 0)
			return 16'($urandom_range(0, 15));
		return 16'($urandom);
	endfunction

	always @(posedge clk) begin
		exec_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report("unexpected result, owner", 16'h0, owner_out);
			end else begin
				want = due_results.pop_front();
				if (status !== want.status)
					report("status", 16'(want.status), 16'(status));
				if (owner_out !== want.owner)
					report("owner_out", want.owner, owner_out);
			end
		end
	end

	// result side: random stalls, idle-free stretches, one long hold-off
	initial begin
		int stall;
		int res_n;
		bit rx_idle;
		bit held;
		out_ready <= 1'b0;
		res_n = 0;
		rx_idle = 1'b1;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (res_n % 40 == 0)
				rx_idle = ($urandom_range(0, 2) != 0);
			stall = rx_idle ? $urandom_range(0, 8) : 0;
			if (!held && sent_count >= 400) begin
				stall = 500;
				held = 1'b1;
			end
			if (stall > 0) begin
				@(negedge clk) out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			res_n++;
		end
	end

	initial begin
		int seg;
		int r;
		bit paused;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= tpt_pkg::KIND_ADD;
		user_id <= '0;
		task_id <= '0;
		priority_req <= '0;
		mismatches = 0;
		sent_count = 0;
		cycles = 0;
		idle_on = 1'b1;
		paused = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			tbl_live[i] = 1'b0;

		directed_rows = '{
			'{tpt_pkg::KIND_EXEC,   16'h1234, 16'h5678, 16'h9abc,
				1'b1, tpt_pkg::STAT_EMPTY,    16'h0000},
			'{tpt_pkg::KIND_EDIT,   16'h0000, 16'h0005, 16'h0100,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_REMOVE, 16'h0000, 16'h0005, 16'h0000,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_ADD,    16'hffff, 16'hffff, 16'hffff,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_ADD,    16'h0000, 16'h0000, 16'h0000,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_ADD,    16'h1234, 16'h0007, 16'hffff,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_ADD,    16'h0042, 16'h0007, 16'h0010,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_EDIT,   16'habcd, 16'h0007, 16'h0020,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_REMOVE, 16'h5555, 16'h0007, 16'h7777,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_EXEC,   16'h0000, 16'h0000, 16'h0000,
				1'b1, tpt_pkg::STAT_EXECUTED, 16'hffff},
			'{tpt_pkg::KIND_ADD,    16'h00a1, 16'h0009, 16'h0030,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_ADD,    16'h00b2, 16'h0009, 16'h0030,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_ADD,    16'h00c3, 16'h0003, 16'h0030,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_ADD,    16'h00c3, 16'h0003, 16'h0030,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_EXEC,   16'hffff, 16'hffff, 16'hffff,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_EXEC,   16'h0000, 16'h0000, 16'h0000,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_EXEC,   16'h0000, 16'h0000, 16'h0000,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_EDIT,   16'h0000, 16'h0003, 16'hffff,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_EXEC,   16'h0000, 16'h0000, 16'h0000,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_EXEC,   16'h0000, 16'h0000, 16'h0000,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_EXEC,   16'h0000, 16'h0000, 16'h0000,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_EXEC,   16'h0000, 16'h0000, 16'h0000,
				1'b1, tpt_pkg::STAT_EMPTY,    16'h0000},
			'{tpt_pkg::KIND_REMOVE, 16'h0000, 16'h0000, 16'h0000,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_ADD,    16'h8000, 16'h8000, 16'h8000,
				1'b0, tpt_pkg::STAT_EXECUTED, 16'h0000},
			'{tpt_pkg::KIND_EXEC,   16'h0000, 16'h0000, 16'h0000,
				1'b1, tpt_pkg::STAT_EXECUTED, 16'h8000}
		};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			issue(directed_rows[i].kind, directed_rows[i].user, directed_rows[i].tid,
				directed_rows[i].prio, directed_rows[i].typed, directed_rows[i].st,
				directed_rows[i].own);
		wait_drained();

		while (sent_count < TOTAL_ITEMS) begin
			if (!paused && sent_count >= 800) begin
				// stop offering until the table has answered everything
				wait_drained();
				paused = 1'b1;
			end
			idle_on = ($urandom_range(0, 3) != 0);
			seg = $urandom_range(0, 9);
			if (seg == 0) begin
				// fill up, then push a few adds into the full table
				while (live_entries() < SLOTS)
					issue(tpt_pkg::KIND_ADD, pick_user(), pick_task(), pick_prio());
				repeat ($urandom_range(1, 3))
					issue(tpt_pkg::KIND_ADD, pick_user(), pick_task(), pick_prio());
			end else if (seg == 1) begin
				while (live_entries() > 0)
					issue(tpt_pkg::KIND_EXEC, pick_user(), 16'($urandom), pick_prio());
				issue(tpt_pkg::KIND_EXEC, pick_user(), 16'($urandom), pick_prio());
			end else begin
				repeat ($urandom_range(20, 60)) begin
					r = $urandom_range(0, 99);
					if (r < 35)
						issue(tpt_pkg::KIND_ADD, pick_user(), pick_task(), pick_prio());
					else if (r < 55)
						issue(tpt_pkg::KIND_EDIT, pick_user(), pick_task(), pick_prio());
					else if (r < 70)
						issue(tpt_pkg::KIND_REMOVE, pick_user(), pick_task(), pick_prio());
					else
						issue(tpt_pkg::KIND_EXEC, pick_user(), 16'($urandom), pick_prio());
				end
			end
		end

		wait_drained();
		// a trailing edit or remove may still be in the chain
		repeat (SLOTS + 16) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/tpt_pkg.sv
hw/rtl/tpt_cell.sv
hw/rtl/task_priority_table.sv
tb/sv/tb.sv
